### rtl/tgrb_pkg.sv
// package for the text glyph row blitter
// holds shared constants, transaction payload types and controller/datapath link types
package tgrb_pkg;

  localparam int unsigned GLYPH_ROWS_DEF = 16;
  localparam int unsigned FONT_DEPTH_DEF = 8192;
  localparam int unsigned CELL_WIDTH     = 8;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_PITCH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_STRIDE = 2'd3;

  localparam logic [13:0] SCREEN_WIDTH_RST = 14'd1024;
  localparam logic [13:0] SCAN_PITCH_RST   = 14'd1024;
  localparam logic [31:0] DRAW_COLOR_RST   = 32'h0000_FF00;
  localparam logic [5:0]  GLYPH_STRIDE_RST = 6'd16;
  localparam logic [14:0] WIDTH_CAP        = 15'd8192;

  localparam logic [1:0] MODE_DRAW = 2'd0;
  localparam logic [1:0] MODE_LOAD = 2'd1;
  localparam logic [1:0] MODE_HOME = 2'd2;

  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_TAB     = 8'd9;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  char_code;
    logic [12:0] font_addr;
    logic [7:0]  font_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_index;
    logic [7:0]  row_bits;
    logic [31:0] pixel_color;
    logic        last_row;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic base;
    logic issue;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic draw_item;
    logic rd_free;
  } stat_t;

endpackage

### rtl/text_glyph_row_blitter_top.sv
// top level of the text glyph row blitter
// depends on tgrb_pkg, tgrb_ctrl, tgrb_dp and tgrb_ram
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+--------------------------
//   input    | in        | in_valid_i / in_ready_o | in_data_i (in_item_t)
//   output   | out       | out_valid_o/out_ready_i | out_data_o (out_item_t)
//   config   | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// load, home, newline, tab and unused-mode transactions leave the controller idle and ready
// a drawn character: multiply, address fold, then one row a cycle while rd_free is high
// the row rate is set by the single font ram port, one glyph byte read per cycle
// an output stall holds the read stage and output register and pauses row reads
// reset clears cursor and control state, presets config registers; font ram is not cleared
module text_glyph_row_blitter_top #(
  parameter int unsigned GLYPH_ROWS = tgrb_pkg::GLYPH_ROWS_DEF,
  parameter int unsigned FONT_DEPTH = tgrb_pkg::FONT_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tgrb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tgrb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tgrb_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tgrb_pkg::out_item_t             out_data_o
);
  import tgrb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tgrb_ctrl #(
    .GLYPH_ROWS(GLYPH_ROWS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  tgrb_dp #(
    .GLYPH_ROWS(GLYPH_ROWS),
    .FONT_DEPTH(FONT_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // a drawn character blocks new transactions until its rows are issued
  a_draw_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && stat.draw_item |=> !in_ready_o)
    else $error("input accepted right after a drawn character");

  // row reads never share the ram port with a font load
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.issue && cmd.accept))
    else $error("row read and transaction accept in the same cycle");

  // a row read only goes out when the read stage can take it
  a_issue_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> stat.rd_free && !in_ready_o)
    else $error("row read issued into a busy read stage");

endmodule

### rtl/tgrb_ram.sv
// generic single port ram with registered read
// no dependencies
module tgrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tgrb_ctrl.sv
// controller state machine of the glyph row blitter
// depends on tgrb_pkg for the command and status types
module tgrb_ctrl #(
  parameter int unsigned GLYPH_ROWS = tgrb_pkg::GLYPH_ROWS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tgrb_pkg::stat_t stat_i,
  output tgrb_pkg::cmd_t  cmd_o
);
  import tgrb_pkg::*;

  localparam int unsigned RW = $clog2(GLYPH_ROWS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_BASE = 2'd2;
  localparam logic [1:0] ST_ROWS = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [RW-1:0] cnt_q, cnt_d;
  cmd_t          cmd;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd        = '0;
    cmd.last   = (cnt_q == RW'(GLYPH_ROWS - 1));
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd.accept = in_valid_i;
        if (in_valid_i && stat_i.draw_item) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_d = ST_BASE;
      end
      ST_BASE: begin
        cmd.base = 1'b1;
        cnt_d    = '0;
        state_d  = ST_ROWS;
      end
      ST_ROWS: begin
        cmd.issue = stat_i.rd_free;
        if (stat_i.rd_free) begin
          cnt_d = cnt_q + RW'(1);
          if (cmd.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### rtl/tgrb_dp.sv
// datapath of the glyph row blitter: config registers, cursor, address math, font ram,
// read stage and output register; depends on tgrb_pkg and tgrb_ram
module tgrb_dp #(
  parameter int unsigned GLYPH_ROWS = tgrb_pkg::GLYPH_ROWS_DEF,
  parameter int unsigned FONT_DEPTH = tgrb_pkg::FONT_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tgrb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tgrb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  tgrb_pkg::in_item_t                  in_data_i,
  input  tgrb_pkg::cmd_t                      cmd_i,
  output tgrb_pkg::stat_t                     stat_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output tgrb_pkg::out_item_t                 out_data_o
);
  import tgrb_pkg::*;

  localparam int unsigned AW = $clog2(FONT_DEPTH);

  localparam logic [16:0] DEPTH_X1 = 17'(FONT_DEPTH);
  localparam logic [16:0] DEPTH_X2 = 17'(2 * FONT_DEPTH);
  localparam logic [16:0] DEPTH_X4 = 17'(4 * FONT_DEPTH);

  // a 14-bit value over a depth of at least 2048 has a quotient below 8
  function automatic logic [AW-1:0] fold(input logic [13:0] v);
    logic [16:0] t;
    t = {3'b0, v};
    if (t >= DEPTH_X4) begin
      t = t - DEPTH_X4;
    end
    if (t >= DEPTH_X2) begin
      t = t - DEPTH_X2;
    end
    if (t >= DEPTH_X1) begin
      t = t - DEPTH_X1;
    end
    return t[AW-1:0];
  endfunction

  logic [13:0] sw_q, pitch_q;
  logic [31:0] color_q;
  logic [5:0]  stride_q;
  logic [12:0] x_q, x_d;
  logic [31:0] y_q, y_d;
  logic [7:0]  code_q;
  logic [13:0] prod_q;
  logic [31:0] mul_q;
  logic [AW-1:0] fa_q;
  logic [31:0] idx_q;
  logic        rd_valid_q;
  logic [31:0] rd_idx_q;
  logic        rd_last_q;
  logic        out_valid_q;
  out_item_t   out_q;

  logic        is_nl, is_tab, is_draw_mode;
  logic        adv, adv_nl;
  logic [14:0] xs, width, xs_chk;
  logic [12:0] adv_x;
  logic [31:0] adv_y;
  logic        move;
  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]  ram_rdata;

  assign is_draw_mode = (in_data_i.mode == MODE_DRAW);
  assign is_nl        = (in_data_i.char_code == CODE_NEWLINE);
  assign is_tab       = (in_data_i.char_code == CODE_TAB);

  assign stat_o.draw_item = is_draw_mode && !is_nl && !is_tab;

  // cursor advance after a character, tab or newline, with line wrap
  assign adv    = (cmd_i.accept && is_draw_mode && (is_nl || is_tab)) || cmd_i.base;
  assign adv_nl = cmd_i.accept && is_nl;
  assign width  = ({1'b0, sw_q} > WIDTH_CAP) ? WIDTH_CAP : {1'b0, sw_q};

  always_comb begin
    adv_y = y_q;
    if (adv_nl) begin
      xs    = '0;
      adv_y = y_q + 32'(GLYPH_ROWS);
    end else begin
      xs = {2'b0, x_q} + 15'(CELL_WIDTH);
    end
    xs_chk = xs + 15'(CELL_WIDTH);
    if (xs_chk > width) begin
      adv_x = '0;
      adv_y = adv_y + 32'(GLYPH_ROWS);
    end else begin
      adv_x = xs[12:0];
    end
  end

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (cmd_i.accept && in_data_i.mode == MODE_HOME) begin
      x_d = '0;
      y_d = '0;
    end else if (adv) begin
      x_d = adv_x;
      y_d = adv_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q     <= SCREEN_WIDTH_RST;
      pitch_q  <= SCAN_PITCH_RST;
      color_q  <= DRAW_COLOR_RST;
      stride_q <= GLYPH_STRIDE_RST;
      x_q      <= '0;
      y_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SCREEN_WIDTH: sw_q     <= cfg_data_i[13:0];
          REG_SCAN_PITCH:   pitch_q  <= cfg_data_i[13:0];
          REG_DRAW_COLOR:   color_q  <= cfg_data_i;
          REG_GLYPH_STRIDE: stride_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  // glyph address and pixel index generation
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      code_q <= in_data_i.char_code;
    end
    if (cmd_i.mul) begin
      prod_q <= 14'(code_q * stride_q);
      mul_q  <= 32'(y_q * pitch_q);
    end
    if (cmd_i.base) begin
      fa_q  <= fold(prod_q);
      idx_q <= {19'b0, x_q} + mul_q;
    end else if (cmd_i.issue) begin
      fa_q  <= (fa_q == AW'(FONT_DEPTH - 1)) ? '0 : fa_q + AW'(1);
      idx_q <= idx_q + {18'b0, pitch_q};
    end
  end

  assign ram_we   = cmd_i.accept && (in_data_i.mode == MODE_LOAD);
  assign ram_addr = cmd_i.issue ? fa_q : fold({1'b0, in_data_i.font_addr});

  tgrb_ram #(
    .WIDTH(8),
    .DEPTH(FONT_DEPTH)
  ) u_font (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (cmd_i.issue),
    .addr_i (ram_addr),
    .wdata_i(in_data_i.font_byte),
    .rdata_o(ram_rdata)
  );

  // read stage feeding the output register
  assign move           = rd_valid_q && (!out_valid_q || out_ready_i);
  assign stat_o.rd_free = !rd_valid_q || move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.issue) begin
        rd_valid_q <= 1'b1;
      end else if (move) begin
        rd_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_idx_q  <= idx_q;
      rd_last_q <= cmd_i.last;
    end
    if (move) begin
      out_q.pixel_index <= rd_idx_q;
      out_q.row_bits    <= ram_rdata;
      out_q.pixel_color <= color_q;
      out_q.last_row    <= rd_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### bench/text_glyph_row_blitter_top_test.sv
`timescale 1ns / 1ps
// self-checking bench for text_glyph_row_blitter_top: draws, tabs, newlines, font loads
// and cursor homes under several register settings, rows checked by a scoreboard class
// depends on tgrb_pkg and the block's rtl
module text_glyph_row_blitter_top_test;
  import tgrb_pkg::*;

  localparam int unsigned GLYPH_ROWS    = GLYPH_ROWS_DEF;
  localparam int unsigned FONT_DEPTH    = FONT_DEPTH_DEF;
  localparam int unsigned X_MASK        = 'h1FFF;
  localparam logic [1:0]  MODE_UNUSED   = 2'd3;
  localparam int unsigned SETTLE_CYCLES = GLYPH_ROWS + 12;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned POOL_SIZE     = 8;
  localparam int unsigned MAX_SHOWN     = 60;

  class glyph_row_tracker;
    logic [13:0] width_reg;
    logic [13:0] pitch_reg;
    logic [31:0] color_reg;
    logic [5:0]  stride_reg;
    int unsigned cur_x;
    logic [31:0] cur_y;
    logic [7:0]  font_mem [FONT_DEPTH];
    out_item_t   rows_due [$];
    int unsigned mismatches;

    function new();
      width_reg  = SCREEN_WIDTH_RST;
      pitch_reg  = SCAN_PITCH_RST;
      color_reg  = DRAW_COLOR_RST;
      stride_reg = GLYPH_STRIDE_RST;
      cur_x      = 0;
      cur_y      = '0;
      mismatches = 0;
    endfunction

    function void report(string msg);
      if (mismatches < MAX_SHOWN) $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SCREEN_WIDTH: width_reg  = data[13:0];
        REG_SCAN_PITCH:   pitch_reg  = data[13:0];
        REG_DRAW_COLOR:   color_reg  = data;
        REG_GLYPH_STRIDE: stride_reg = data[5:0];
        default: ;
      endcase
    endfunction

    function void next_line();
      cur_x = 0;
      cur_y = cur_y + 32'(GLYPH_ROWS);
    endfunction

    function void note_char(in_item_t item);
      out_item_t   row;
      logic [31:0] line;
      logic [63:0] idx;
      int unsigned fa;
      int unsigned lim;
      if (item.mode == MODE_LOAD) begin
        font_mem[item.font_addr] = item.font_byte;
      end else if (item.mode == MODE_HOME) begin
        cur_x = 0;
        cur_y = '0;
      end else if (item.mode == MODE_DRAW) begin
        if (item.char_code == CODE_NEWLINE) begin
          next_line();
        end else if (item.char_code == CODE_TAB) begin
          cur_x += CELL_WIDTH;
        end else begin
          for (int r = 0; r < GLYPH_ROWS; r++) begin
            line = cur_y + 32'(r);
            idx  = 64'(cur_x) + 64'(line) * 64'(pitch_reg);
            fa   = (int'(item.char_code) * int'(stride_reg) + r) % FONT_DEPTH;
            row.pixel_index = idx[31:0];
            row.row_bits    = font_mem[fa];
            row.pixel_color = color_reg;
            row.last_row    = (r == GLYPH_ROWS - 1);
            rows_due.push_back(row);
          end
          cur_x += CELL_WIDTH;
        end
        lim = (width_reg > WIDTH_CAP) ? WIDTH_CAP : width_reg;
        if (cur_x + CELL_WIDTH > lim) next_line();
        cur_x &= X_MASK;
      end
    endfunction

    function void check_row(out_item_t got);
      out_item_t want;
      if (rows_due.size() == 0) begin
        report($sformatf("row with nothing due, index %0h bits %0h",
                         got.pixel_index, got.row_bits));
        return;
      end
      want = rows_due.pop_front();
      if (got.pixel_index !== want.pixel_index)
        report($sformatf("pixel_index %0h, want %0h", got.pixel_index, want.pixel_index));
      if (got.row_bits !== want.row_bits)
        report($sformatf("row_bits %0h, want %0h at index %0h",
                         got.row_bits, want.row_bits, want.pixel_index));
      if (got.pixel_color !== want.pixel_color)
        report($sformatf("pixel_color %0h, want %0h", got.pixel_color, want.pixel_color));
      if (got.last_row !== want.last_row)
        report($sformatf("last_row %0b, want %0b at index %0h",
                         got.last_row, want.last_row, want.pixel_index));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_data_o;

  glyph_row_tracker tracker;
  bit          glyph_loaded [FONT_DEPTH];
  logic [7:0]  pool [POOL_SIZE];
  int unsigned sent;
  bit          send_burst;
  bit          take_burst;
  bit          long_hold;

  text_glyph_row_blitter_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) tracker.note_char(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_row(out_data_o);
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(input in_item_t item);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic load_byte(input logic [12:0] addr, input logic [7:0] value);
    in_item_t item;
    item.mode      = MODE_LOAD;
    item.char_code = 8'($urandom);
    item.font_addr = addr;
    item.font_byte = value;
    glyph_loaded[addr] = 1'b1;
    send_item(item);
  endtask

  // loads any glyph row that would otherwise be read unwritten
  task automatic draw_code(input logic [7:0] code);
    in_item_t    item;
    int unsigned fa;
    if (code != CODE_NEWLINE && code != CODE_TAB) begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        fa = (int'(code) * int'(tracker.stride_reg) + r) % FONT_DEPTH;
        if (!glyph_loaded[fa]) load_byte(13'(fa), pick_byte());
      end
    end
    item.mode      = MODE_DRAW;
    item.char_code = code;
    item.font_addr = 13'($urandom);
    item.font_byte = 8'($urandom);
    send_item(item);
  endtask

  task automatic send_ctl(input logic [1:0] mode);
    in_item_t item;
    item.mode      = mode;
    item.char_code = 8'($urandom);
    item.font_addr = 13'($urandom);
    item.font_byte = 8'($urandom);
    send_item(item);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.rows_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    tracker.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned width, input int unsigned pitch,
                           input logic [31:0] color, input int unsigned stride,
                           input int unsigned count);
    int unsigned target;
    int unsigned sel;
    settle();
    write_reg(REG_SCREEN_WIDTH, 32'(width));
    write_reg(REG_SCAN_PITCH, 32'(pitch));
    write_reg(REG_DRAW_COLOR, color);
    write_reg(REG_GLYPH_STRIDE, 32'(stride));
    for (int i = 0; i < POOL_SIZE; i++)
      pool[i] = (i == 0) ? 8'd0 : (i == 1) ? 8'd255 : 8'($urandom_range(0, 255));
    target = sent + count;
    while (sent < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 60)      draw_code(pool[$urandom_range(0, POOL_SIZE - 1)]);
      else if (sel < 70) draw_code(8'($urandom_range(0, 255)));
      else if (sel < 78) draw_code(sel[0] ? CODE_TAB : CODE_NEWLINE);
      else if (sel < 88) load_byte(13'($urandom_range(0, FONT_DEPTH - 1)), pick_byte());
      else if (sel < 94) send_ctl(MODE_HOME);
      else               send_ctl(MODE_UNUSED);
    end
  endtask

  initial begin : take_rows
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (long_hold) begin
        stall     = LONG_HOLD;
        long_hold = 1'b0;
      end else begin
        stall = take_burst ? 0 : $urandom_range(0, 10);
      end
      if (stall != 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        do @(posedge clk_i); while (!out_valid_o);
        repeat (stall) @(negedge clk_i);
      end else begin
        @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    #8000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    sent       = 0;
    send_burst = 1'b0;
    take_burst = 1'b0;
    long_hold  = 1'b0;
    tracker    = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // glyph for code 0 with edge row patterns, then every transaction kind
    for (int r = 0; r < GLYPH_ROWS; r++)
      load_byte(13'(r), (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : (r == 2) ? 8'h80 :
                        (r == 3) ? 8'h01 : 8'($urandom));
    draw_code(8'd0);
    draw_code(CODE_NEWLINE);
    draw_code(CODE_TAB);
    draw_code(8'd0);
    send_ctl(MODE_UNUSED);
    send_ctl(MODE_HOME);
    load_byte(13'h1FFF, pick_byte());
    draw_code(8'd0);

    long_hold  = 1'b1;
    send_burst = 1'b1;
    run_phase(1024, 1024, 32'h0000_FF00, 16, 40);
    send_burst = 1'b0;
    run_phase(8, 1, 32'h0000_0000, 32, 45);
    run_phase(16383, 16383, 32'hFFFF_FFFF, 63, 45);
    run_phase(0, 0, $urandom, 0, 40);
    run_phase(7, 8192, $urandom, 16, 40);
    send_burst = 1'b1;
    take_burst = 1'b1;
    run_phase($urandom_range(8, 200), $urandom_range(1, 8192), $urandom,
              $urandom_range(16, 32), 45);
    send_burst = 1'b0;
    take_burst = 1'b0;
    run_phase(8192, $urandom_range(0, 16383), $urandom, $urandom_range(0, 63), 45);
    run_phase($urandom_range(8, 120), $urandom_range(1, 4096), $urandom,
              $urandom_range(16, 32), 45);

    settle();
    if (tracker.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
